// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rhht_pkg.sv =====
package rhht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int DIST_BITS   = 7;
    localparam int KEY_BITS    = 32;
    localparam int COUNT_BITS  = 32;
    localparam int ADD_BITS    = 16;
    localparam int TOTAL_BITS  = 48;
    localparam int LIMIT_BITS  = 7;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(44);
    localparam logic [DIST_BITS-1:0]  DEPTH_DIST  = DIST_BITS'(TABLE_DEPTH);

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_NEW   = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [31:0]         delta_usec;
        logic [ADD_BITS-1:0] add_count;
        logic [5:0]          slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic                  slot_valid;
        logic [31:0]           slot_key;
        logic [31:0]           slot_count;
        logic [6:0]            slot_distance;
        logic [6:0]            entries_in_use;
        logic [6:0]            longest_probe_seen;
        logic [TOTAL_BITS-1:0] total_samples;
        logic [31:0]           smallest_key;
        logic [31:0]           largest_key;
    } t_out_item;

    typedef struct packed {
        logic [DIST_BITS-1:0]  probe_dist;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        t_entry               wr_entry;
    } t_mem_req;

endpackage

// ===== src/rhht_mem.sv =====
module rhht_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rhht_pkg::t_mem_req  i_req,
    output rhht_pkg::t_entry    o_rd_entry
);

    rhht_pkg::t_entry                     r_mem [rhht_pkg::TABLE_DEPTH];
    rhht_pkg::t_entry                     r_rd_entry;
    logic [rhht_pkg::TABLE_DEPTH-1:0]     r_valid;
    logic                                 r_rd_valid;

    // table storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    // per-slot occupied flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    // an empty slot reads as all zero
    assign o_rd_entry = r_rd_valid ? r_rd_entry : '0;

endmodule

// ===== src/rhht_ctrl.sv =====
module rhht_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rhht_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    input  logic [rhht_pkg::LIMIT_BITS-1:0]     i_cfg_data,
    output rhht_pkg::t_mem_req                  o_mem_req,
    input  rhht_pkg::t_entry                    i_rd_entry,
    input  logic                                i_out_free,
    output logic                                o_push,
    output rhht_pkg::t_out_item                 o_out_item
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic                                 r_state, n_state;
    logic [rhht_pkg::LIMIT_BITS-1:0]      r_limit, n_limit;
    logic [rhht_pkg::DIST_BITS-1:0]       r_occ, n_occ;
    logic [rhht_pkg::DIST_BITS-1:0]       r_maxd, n_maxd;
    logic [rhht_pkg::TOTAL_BITS-1:0]      r_total, n_total;
    logic [rhht_pkg::KEY_BITS-1:0]        r_min, n_min;
    logic [rhht_pkg::KEY_BITS-1:0]        r_max, n_max;

    logic                                 r_cmd, n_cmd;
    logic                                 r_place, n_place;
    logic [rhht_pkg::KEY_BITS-1:0]        r_key, n_key;
    logic [rhht_pkg::ADD_BITS-1:0]        r_add, n_add;
    logic [rhht_pkg::KEY_BITS-1:0]        r_ckey, n_ckey;
    logic [rhht_pkg::COUNT_BITS-1:0]      r_cnt, n_cnt;
    logic [rhht_pkg::DIST_BITS-1:0]       r_d, n_d;
    logic [rhht_pkg::SLOT_BITS-1:0]       r_p, n_p;

    logic                                 q_valid;
    logic                                 key_hit;
    logic                                 shorter;
    logic                                 full;
    logic [rhht_pkg::LIMIT_BITS-1:0]      lim;
    logic [rhht_pkg::COUNT_BITS:0]        cnt_sum;
    logic [rhht_pkg::COUNT_BITS-1:0]      cnt_sat;
    logic [rhht_pkg::TOTAL_BITS:0]        tot_sum;
    logic [rhht_pkg::TOTAL_BITS-1:0]      tot_sat;
    logic [rhht_pkg::SLOT_BITS-1:0]       start_addr;
    logic [rhht_pkg::SLOT_BITS-1:0]       next_p;
    logic [1:0]                           st;
    logic                                 s_valid;
    rhht_pkg::t_entry                     s_entry;

    always_comb begin
        q_valid = (i_rd_entry.probe_dist != '0);
        key_hit = q_valid && (i_rd_entry.key == r_key);
        shorter = (i_rd_entry.probe_dist < r_d);
        lim     = (r_limit < rhht_pkg::DEPTH_DIST) ? r_limit : rhht_pkg::DEPTH_DIST;
        full    = (r_occ >= lim);
        cnt_sum = {1'b0, i_rd_entry.count} + (rhht_pkg::COUNT_BITS+1)'(r_add);
        cnt_sat = cnt_sum[rhht_pkg::COUNT_BITS] ? '1 : cnt_sum[rhht_pkg::COUNT_BITS-1:0];
        tot_sum = {1'b0, r_total} + (rhht_pkg::TOTAL_BITS+1)'(r_add);
        tot_sat = tot_sum[rhht_pkg::TOTAL_BITS] ? '1 : tot_sum[rhht_pkg::TOTAL_BITS-1:0];
        next_p  = r_p + rhht_pkg::SLOT_BITS'(1);
        start_addr = (i_in_item.cmd == rhht_pkg::CMD_READ) ?
                     i_in_item.slot_index[rhht_pkg::SLOT_BITS-1:0] :
                     i_in_item.delta_usec[rhht_pkg::SLOT_BITS-1:0] + rhht_pkg::SLOT_BITS'(1);

        n_state = r_state;
        n_limit = i_cfg_valid ? i_cfg_data : r_limit;
        n_occ   = r_occ;
        n_maxd  = r_maxd;
        n_total = r_total;
        n_min   = r_min;
        n_max   = r_max;
        n_cmd   = r_cmd;
        n_place = r_place;
        n_key   = r_key;
        n_add   = r_add;
        n_ckey  = r_ckey;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_p     = r_p;
        o_mem_req = '0;
        o_push  = 1'b0;
        st      = rhht_pkg::ST_READ;
        s_valid = 1'b0;
        s_entry = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                    n_cmd   = i_in_item.cmd;
                    n_key   = i_in_item.delta_usec;
                    n_ckey  = i_in_item.delta_usec;
                    n_add   = i_in_item.add_count;
                    n_cnt   = rhht_pkg::COUNT_BITS'(i_in_item.add_count);
                    n_d     = rhht_pkg::DIST_BITS'(1);
                    n_place = 1'b0;
                    n_p     = start_addr;
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = start_addr;
                end
            end
            S_EVAL: begin
                if (i_out_free) begin
                    if (r_cmd == rhht_pkg::CMD_READ) begin
                        o_push  = 1'b1;
                        st      = rhht_pkg::ST_READ;
                        s_valid = q_valid;
                        s_entry = i_rd_entry;
                        n_state = S_IDLE;
                    end else if (!r_place && key_hit) begin
                        // same key found, bump its count
                        o_mem_req.wr_en    = 1'b1;
                        o_mem_req.wr_addr  = r_p;
                        o_mem_req.wr_entry = '{probe_dist: i_rd_entry.probe_dist,
                                               key: i_rd_entry.key, count: cnt_sat};
                        n_total = tot_sat;
                        o_push  = 1'b1;
                        st      = rhht_pkg::ST_MERGE;
                        n_state = S_IDLE;
                    end else if (!r_place && full &&
                                 (!q_valid || shorter || r_d == rhht_pkg::DEPTH_DIST)) begin
                        // key is absent and the table is at its limit
                        o_push  = 1'b1;
                        st      = rhht_pkg::ST_DROP;
                        n_state = S_IDLE;
                    end else if (!q_valid) begin
                        // free slot ends the chain
                        o_mem_req.wr_en    = 1'b1;
                        o_mem_req.wr_addr  = r_p;
                        o_mem_req.wr_entry = '{probe_dist: r_d, key: r_ckey, count: r_cnt};
                        n_occ   = r_occ + rhht_pkg::DIST_BITS'(1);
                        n_maxd  = (r_d > r_maxd) ? r_d : r_maxd;
                        n_total = tot_sat;
                        n_min   = (r_key < r_min) ? r_key : r_min;
                        n_max   = (r_key > r_max) ? r_key : r_max;
                        o_push  = 1'b1;
                        st      = rhht_pkg::ST_NEW;
                        n_state = S_IDLE;
                    end else if (shorter) begin
                        // resident is closer to home: take its slot, carry it on
                        o_mem_req.wr_en    = 1'b1;
                        o_mem_req.wr_addr  = r_p;
                        o_mem_req.wr_entry = '{probe_dist: r_d, key: r_ckey, count: r_cnt};
                        n_maxd  = (r_d > r_maxd) ? r_d : r_maxd;
                        n_ckey  = i_rd_entry.key;
                        n_cnt   = i_rd_entry.count;
                        n_d     = i_rd_entry.probe_dist + rhht_pkg::DIST_BITS'(1);
                        n_place = 1'b1;
                        n_p     = next_p;
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = next_p;
                    end else begin
                        n_d     = r_d + rhht_pkg::DIST_BITS'(1);
                        n_p     = next_p;
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = next_p;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_out_item.status             = st;
        o_out_item.slot_valid         = s_valid;
        o_out_item.slot_key           = s_entry.key;
        o_out_item.slot_count         = s_entry.count;
        o_out_item.slot_distance      = s_entry.probe_dist;
        o_out_item.entries_in_use     = n_occ;
        o_out_item.longest_probe_seen = n_maxd;
        o_out_item.total_samples      = n_total;
        o_out_item.smallest_key       = n_min;
        o_out_item.largest_key        = n_max;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= rhht_pkg::LIMIT_RESET;
            r_occ   <= '0;
            r_maxd  <= '0;
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_limit <= n_limit;
            r_occ   <= n_occ;
            r_maxd  <= n_maxd;
            r_total <= n_total;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_place <= n_place;
        r_key   <= n_key;
        r_add   <= n_add;
        r_ckey  <= n_ckey;
        r_cnt   <= n_cnt;
        r_d     <= n_d;
        r_p     <= n_p;
    end

endmodule

// ===== src/rhht_outreg.sv =====
module rhht_outreg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rhht_pkg::t_out_item  i_item,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhht_pkg::t_out_item  o_item
);

    logic                 r_valid, n_valid;
    rhht_pkg::t_out_item  r_item;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_push || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/robin_hood_histogram_table.sv =====
// histogram of duration keys in a 64-slot open-addressed table, robin hood probing
// input channel (i_in_valid / o_in_ready / i_in_item): one item is an add (key and
//   count) or a read of one slot; one result item comes back for every input item
// config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): entry limit, always ready,
//   write it only while no item is in flight
// result channel (o_out_valid / i_out_ready / o_out_item): status, slot contents on a
//   read, and the table totals after the item
// probe walk: the first table read is issued in the accepting cycle, then each slot
//   on the probe chain is read and evaluated in turn (lookup, then displacement of
//   shorter residents); the result is written to the output register when the chain
//   ends and is then offered on the result channel
// item flow: one item at a time; the next item is taken the cycle after a result is
//   written to the output register, and not while an item walks its chain; the single
//   table memory port pair paces the walk
// receiver stall: a finished result waits in the output register while the next item
//   is accepted; that item waits at its first probe step until the register frees up,
//   then walks its chain without further stalls
// reset: slot occupied flags clear at once, totals clear, smallest key goes to all
//   ones, entry limit returns to 44; no clearing pass
module robin_hood_histogram_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rhht_pkg::t_in_item               i_in_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rhht_pkg::LIMIT_BITS-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rhht_pkg::t_out_item              o_out_item
);

    rhht_pkg::t_mem_req   mem_req;
    rhht_pkg::t_entry     rd_entry;
    rhht_pkg::t_out_item  res_item;
    logic                 res_push;
    logic                 out_free;

    // entry limit register lives in the sequencer and takes every write
    assign o_cfg_ready = 1'b1;

    // slot table: key, count and probe distance per slot, one read and one write a cycle
    rhht_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

    // probe sequencer: slot reads, or lookup, merge, drop check, then displacement walk
    rhht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_mem_req  (mem_req),
        .i_rd_entry (rd_entry),
        .i_out_free (out_free),
        .o_push     (res_push),
        .o_out_item (res_item)
    );

    // result register decouples the sequencer from the receiver
    rhht_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (res_item),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ===== src/rhht_checker.sv =====
`include "assert_macros.svh"

module rhht_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input rhht_pkg::t_in_item               i_in_item,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [rhht_pkg::LIMIT_BITS-1:0]  i_cfg_data,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input rhht_pkg::t_out_item              o_out_item
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result changed while stalled")

    // one item in work at a time
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

    // slot fields are zero unless a read found an entry, and an entry has a distance
    `ASSERT_IMPLY(a_slot_fields, i_clk, i_rst_n, o_out_valid && !o_out_item.slot_valid, o_out_item.slot_key == '0 && o_out_item.slot_count == '0 && o_out_item.slot_distance == '0, "slot fields set without a valid slot")
    `ASSERT_IMPLY(a_slot_dist, i_clk, i_rst_n, o_out_valid && o_out_item.slot_valid, o_out_item.status == rhht_pkg::ST_READ && o_out_item.slot_distance != '0, "valid slot without read or distance")

    // key range and longest probe are consistent with occupancy
    `ASSERT_IMPLY(a_key_range, i_clk, i_rst_n, o_out_valid && o_out_item.entries_in_use != '0, o_out_item.smallest_key <= o_out_item.largest_key && o_out_item.longest_probe_seen != '0, "key range or probe stats inconsistent")

endmodule

bind robin_hood_histogram_table rhht_checker u_rhht_checker (.*);
